/* design/ede_pkg.sv */
// ----------------------------------------------------------------------------
// ede_pkg
// Shared command codes and sequencer state type for the edit distance engine.
// ----------------------------------------------------------------------------
package ede_pkg;

    // Command codes carried by the cmd field
    localparam logic [1:0] CMD_CLEAR    = 2'd0;
    localparam logic [1:0] CMD_APPEND_A = 2'd1;
    localparam logic [1:0] CMD_APPEND_B = 2'd2;
    localparam logic [1:0] CMD_COMPUTE  = 2'd3;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INIT,
        ST_ROW_START,
        ST_ROW_RUN
    } state_t;

endpackage

/* design/ede_ram.sv */
// ----------------------------------------------------------------------------
// ede_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data that holds its value while no read is issued.
// ----------------------------------------------------------------------------
module ede_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* design/edit_distance_engine_core.sv */
// ----------------------------------------------------------------------------
// edit_distance_engine_core
// Levenshtein edit distance between two byte strings held in on-chip RAM.
//
// Input channel (in_valid / in_ready, cmd, char_in): each word is a command.
// Clear empties both strings and the drop flag; append A / append B store
// char_in at the end of that string (dropped and flagged when the string
// already holds MAX_LEN bytes); compute runs the distance.
// Output channel (out_valid / out_ready, distance, truncated): one word per
// compute, held in an output register until taken.
// Clear and append are accepted back to back, also while a result waits.
// Compute with an empty string loads its result directly from idle.
// Otherwise the cost row RAM is first seeded with the column indices,
// then each of the LA rows runs a setup state and then one column per
// cycle, reading and writing the cost row RAM in the same cycle. No input
// is taken during a compute, and a compute is not accepted while an
// earlier result is still held and not taken.
// Reset empties both strings and clears the flag; no clearing pass is run.
// ----------------------------------------------------------------------------
module edit_distance_engine_core #(
    parameter int MAX_LEN = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] cmd,
    input  logic [7:0] char_in,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [6:0] distance,
    output logic       truncated
);

    import ede_pkg::*;

    localparam int LW  = $clog2(MAX_LEN + 1);
    localparam int SAW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam logic [LW-1:0] FULL = LW'(MAX_LEN);
    localparam logic [LW-1:0] ONE  = LW'(1);

    // Control and payload registers
    state_t        state_reg, state_next;
    logic [LW-1:0] len_a_reg, len_a_next;
    logic [LW-1:0] len_b_reg, len_b_next;
    logic          ovf_reg, ovf_next;
    logic [LW-1:0] row_reg, row_next;
    logic [LW-1:0] col_reg, col_next;
    logic [LW-1:0] left_reg, left_next;
    logic [LW-1:0] diag_reg, diag_next;
    logic          out_valid_reg, out_valid_next;
    logic [LW-1:0] dist_reg, dist_next;
    logic          trunc_reg, trunc_next;

    // RAM ports
    logic           a_we, a_re, b_we, b_re, c_we, c_re;
    logic [SAW-1:0] a_waddr, a_raddr, b_waddr, b_raddr;
    logic [LW-1:0]  c_waddr, c_raddr, c_wdata, c_rdata;
    logic [7:0]     a_rdata, b_rdata;

    // Datapath helpers
    logic          accept;
    logic [LW-1:0] row_m1, col_m1, min_lu, min3, cell_val;
    logic [LW+6:0] dist_ext;

    ede_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_str_a (
        .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(char_in),
        .re(a_re), .raddr(a_raddr), .rdata(a_rdata)
    );

    ede_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_str_b (
        .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(char_in),
        .re(b_re), .raddr(b_raddr), .rdata(b_rdata)
    );

    ede_ram #(.WIDTH(LW), .DEPTH(MAX_LEN + 1), .ADDR_W(LW)) u_cost (
        .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
        .re(c_re), .raddr(c_raddr), .rdata(c_rdata)
    );

    // Handshake: compute waits for a free output slot
    assign in_ready = (state_reg == ST_IDLE) &&
                      ((cmd != CMD_COMPUTE) || !out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    // One DP cell: match copies diagonal, else 1 + min of neighbors
    assign row_m1   = row_reg - ONE;
    assign col_m1   = col_reg - ONE;
    assign min_lu   = (left_reg < c_rdata) ? left_reg : c_rdata;
    assign min3     = (min_lu < diag_reg) ? min_lu : diag_reg;
    assign cell_val = (a_rdata == b_rdata) ? diag_reg : (min3 + ONE);

    // Outputs
    assign dist_ext  = {7'b0, dist_reg};
    assign distance  = dist_ext[6:0];
    assign truncated = trunc_reg;
    assign out_valid = out_valid_reg;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_a_reg     <= '0;
            len_b_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_a_reg     <= len_a_next;
            len_b_reg     <= len_b_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working registers, no reset needed
    always_ff @(posedge clk)
    begin
        row_reg   <= row_next;
        col_reg   <= col_next;
        left_reg  <= left_next;
        diag_reg  <= diag_next;
        dist_reg  <= dist_next;
        trunc_reg <= trunc_next;
    end

    // Next state, RAM control and result loading
    always_comb
    begin
        state_next     = state_reg;
        len_a_next     = len_a_reg;
        len_b_next     = len_b_reg;
        ovf_next       = ovf_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        left_next      = left_reg;
        diag_next      = diag_reg;
        dist_next      = dist_reg;
        trunc_next     = trunc_reg;
        out_valid_next = out_valid_reg && !out_ready;

        a_we    = 1'b0;
        b_we    = 1'b0;
        c_we    = 1'b0;
        a_re    = 1'b0;
        b_re    = 1'b0;
        c_re    = 1'b0;
        a_waddr = len_a_reg[SAW-1:0];
        b_waddr = len_b_reg[SAW-1:0];
        a_raddr = row_m1[SAW-1:0];
        b_raddr = col_m1[SAW-1:0];
        c_waddr = col_reg;
        c_wdata = col_reg;
        c_raddr = col_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd)
                        CMD_CLEAR:
                        begin
                            len_a_next = '0;
                            len_b_next = '0;
                            ovf_next   = 1'b0;
                        end
                        CMD_APPEND_A:
                        begin
                            if (len_a_reg != FULL)
                            begin
                                a_we       = 1'b1;
                                len_a_next = len_a_reg + ONE;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        CMD_APPEND_B:
                        begin
                            if (len_b_reg != FULL)
                            begin
                                b_we       = 1'b1;
                                len_b_next = len_b_reg + ONE;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            // compute: empty string short-cuts to other length
                            trunc_next = ovf_reg;
                            if ((len_a_reg == '0) || (len_b_reg == '0))
                            begin
                                dist_next      = len_a_reg | len_b_reg;
                                out_valid_next = 1'b1;
                            end
                            else
                            begin
                                col_next   = ONE;
                                state_next = ST_INIT;
                            end
                        end
                    endcase
                end
            end

            ST_INIT:
            begin
                // seed cost row with column index
                c_we = 1'b1;
                if (col_reg == len_b_reg)
                begin
                    row_next   = ONE;
                    state_next = ST_ROW_START;
                end
                else
                begin
                    col_next = col_reg + ONE;
                end
            end

            ST_ROW_START:
            begin
                // fetch row byte and first column operands
                a_re      = 1'b1;
                b_re      = 1'b1;
                c_re      = 1'b1;
                b_raddr   = '0;
                c_raddr   = ONE;
                col_next  = ONE;
                left_next = row_reg;
                diag_next = row_m1;
                state_next = ST_ROW_RUN;
            end

            default:
            begin
                // ST_ROW_RUN: write this cell, fetch the next column
                c_we      = 1'b1;
                c_wdata   = cell_val;
                left_next = cell_val;
                diag_next = c_rdata;
                if (col_reg != len_b_reg)
                begin
                    b_re     = 1'b1;
                    c_re     = 1'b1;
                    b_raddr  = col_reg[SAW-1:0];
                    c_raddr  = col_reg + ONE;
                    col_next = col_reg + ONE;
                end
                else if (row_reg == len_a_reg)
                begin
                    dist_next      = cell_val;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    row_next   = row_reg + ONE;
                    state_next = ST_ROW_START;
                end
            end
        endcase
    end

endmodule
